// ----- src/ocwm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ocwm_pkg;

    localparam int unsigned ITER_STEPS = 16;
    localparam int unsigned CNT_W      = $clog2(ITER_STEPS);

    localparam logic [1:0] REG_WHEEL_LIMIT  = 2'd0;
    localparam logic [1:0] REG_ENTER_MARGIN = 2'd1;
    localparam logic [1:0] REG_EXIT_MARGIN  = 2'd2;
    localparam logic [1:0] REG_TIMEOUT      = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_INIT,
        ST_ITER,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             ld_in;
        logic             prep;
        logic             mul;
        logic             init;
        logic             step;
        logic [CNT_W-1:0] cnt;
        logic             ld_out;
    } t_cmd;

    typedef struct packed {
        logic [14:0] wheel_limit;
        logic [15:0] enter_margin;
        logic [15:0] exit_margin;
        logic [7:0]  timeout;
    } t_cfg;

endpackage
`default_nettype wire

// ----- src/omni_chassis_wheel_mixer_unit.sv -----
// Omni chassis wheel mixer.
// Input channel (i_in_valid / o_in_ready) carries one control tick: drive mode,
// commanded forward, sideways and spin speeds, the target travel speed and the
// four measured wheel speeds. Output channel (o_out_valid / i_out_ready) carries
// the four negated wheel targets, the measured body speeds, the travel
// magnitude and the acceleration flag.
// Configuration writes use i_cfg_valid / o_cfg_ready with a register index and
// data; the port is always ready and unknown indexes are ignored.
// The item is captured at the edge that accepts it; its result then passes
// through mixing, one multiply stage, set-up, 16 steps of a shared
// iteration in which four restoring dividers (wheel scaling) and a bit-pair
// square root (travel magnitude) run side by side, and the output load. The
// block takes a new item only once the previous one has been loaded out.
// A finished result sits in an output register; a new item is accepted while
// it waits, and the block only holds at its last step if the previous result
// is still untaken.
// Reset (synchronous, active low) restores the register defaults, clears the
// acceleration flag and tick count, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module omni_chassis_wheel_mixer_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_normal_mode,
    input  wire logic signed [15:0] i_cmd_forward,
    input  wire logic signed [15:0] i_cmd_sideways,
    input  wire logic signed [15:0] i_cmd_spin,
    input  wire logic [15:0]        i_target_travel,
    input  wire logic signed [15:0] i_meas_left_front,
    input  wire logic signed [15:0] i_meas_right_front,
    input  wire logic signed [15:0] i_meas_left_back,
    input  wire logic signed [15:0] i_meas_right_back,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [15:0]      o_target_left_front,
    output logic signed [15:0]      o_target_right_front,
    output logic signed [15:0]      o_target_left_back,
    output logic signed [15:0]      o_target_right_back,
    output logic signed [15:0]      o_body_forward,
    output logic signed [15:0]      o_body_sideways,
    output logic signed [15:0]      o_body_spin,
    output logic [15:0]             o_travel_magnitude,
    output logic                    o_accel_flag,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [7:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);
    import ocwm_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    // Configuration registers. Wheel limit and timeout writes keep only the low
    // bits; an index beyond the register list is accepted and dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wheel_limit  <= 15'd8000;
            r_cfg.enter_margin <= 16'd4000;
            r_cfg.exit_margin  <= 16'd1500;
            r_cfg.timeout      <= 8'd200;
        end else if (i_cfg_valid && i_cfg_index[7:2] == '0) begin
            case (i_cfg_index[1:0])
                REG_WHEEL_LIMIT:  r_cfg.wheel_limit  <= i_cfg_data[14:0];
                REG_ENTER_MARGIN: r_cfg.enter_margin <= i_cfg_data;
                REG_EXIT_MARGIN:  r_cfg.exit_margin  <= i_cfg_data;
                REG_TIMEOUT:      r_cfg.timeout      <= i_cfg_data[7:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    ocwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    ocwm_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_cfg                (r_cfg),
        .i_normal_mode        (i_normal_mode),
        .i_cmd_forward        (i_cmd_forward),
        .i_cmd_sideways       (i_cmd_sideways),
        .i_cmd_spin           (i_cmd_spin),
        .i_target_travel      (i_target_travel),
        .i_meas_left_front    (i_meas_left_front),
        .i_meas_right_front   (i_meas_right_front),
        .i_meas_left_back     (i_meas_left_back),
        .i_meas_right_back    (i_meas_right_back),
        .o_target_left_front  (o_target_left_front),
        .o_target_right_front (o_target_right_front),
        .o_target_left_back   (o_target_left_back),
        .o_target_right_back  (o_target_right_back),
        .o_body_forward       (o_body_forward),
        .o_body_sideways      (o_body_sideways),
        .o_body_spin          (o_body_spin),
        .o_travel_magnitude   (o_travel_magnitude),
        .o_accel_flag         (o_accel_flag)
    );

endmodule
`default_nettype wire

// ----- src/ocwm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ocwm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ocwm_pkg::t_cmd     o_cmd
);
    import ocwm_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_PREP;
            ST_PREP: n_state = ST_MUL;
            ST_MUL:  n_state = ST_INIT;
            ST_INIT: n_state = ST_ITER;
            ST_ITER: if (r_cnt == CNT_W'(ITER_STEPS - 1)) n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.cnt   = r_cnt;
        o_in_ready  = 1'b0;
        n_cnt       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.ld_in  = i_in_valid;
            end
            ST_PREP: o_cmd.prep = 1'b1;
            ST_MUL:  o_cmd.mul  = 1'b1;
            ST_INIT: o_cmd.init = 1'b1;
            ST_ITER: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_out_valid  = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ----- src/ocwm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ocwm_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ocwm_pkg::t_cmd     i_cmd,
    input  wire ocwm_pkg::t_cfg     i_cfg,
    input  wire logic               i_normal_mode,
    input  wire logic signed [15:0] i_cmd_forward,
    input  wire logic signed [15:0] i_cmd_sideways,
    input  wire logic signed [15:0] i_cmd_spin,
    input  wire logic [15:0]        i_target_travel,
    input  wire logic signed [15:0] i_meas_left_front,
    input  wire logic signed [15:0] i_meas_right_front,
    input  wire logic signed [15:0] i_meas_left_back,
    input  wire logic signed [15:0] i_meas_right_back,
    output logic signed [15:0]      o_target_left_front,
    output logic signed [15:0]      o_target_right_front,
    output logic signed [15:0]      o_target_left_back,
    output logic signed [15:0]      o_target_right_back,
    output logic signed [15:0]      o_body_forward,
    output logic signed [15:0]      o_body_sideways,
    output logic signed [15:0]      o_body_spin,
    output logic [15:0]             o_travel_magnitude,
    output logic                    o_accel_flag
);
    import ocwm_pkg::*;

    // Captured item.
    logic               r_mode;
    logic signed [15:0] r_f, r_s, r_w;
    logic [15:0]        r_tgt;
    logic signed [15:0] r_meas [4];

    // Mixing and body stage.
    logic signed [17:0] r_wheel [4];
    logic [16:0]        r_mag [4];
    logic [16:0]        r_max;
    logic signed [15:0] r_bf, r_bs, r_bw;

    // Products and iteration registers.
    logic [31:0] r_prod [4];
    logic [31:0] r_sqf, r_sqs;
    logic [16:0] r_rem [4];
    logic [15:0] r_quo [4];
    logic [31:0] r_op, r_res, r_one;

    // Acceleration detector state.
    logic        r_act;
    logic [7:0]  r_ticks;

    logic signed [17:0] wheel_c [4];
    logic [16:0]        mag_c [4];
    logic [16:0]        max_c;
    logic signed [16:0] m_c [4];
    logic signed [19:0] comb_c [3];
    logic signed [15:0] quar_c [3];
    logic [31:0]        sq_sum;

    function automatic logic signed [15:0] quarter_sat(input logic signed [19:0] v);
        logic signed [19:0] q;
        q = (v + (v < 0 ? 20'sd3 : 20'sd0)) >>> 2;
        if (q > 20'sd32767) return 16'sh7fff;
        else if (q < -20'sd32768) return 16'sh8000;
        else return q[15:0];
    endfunction

    always_comb begin
        if (r_mode) begin
            wheel_c[0] = 18'(r_f) + 18'(r_s) + 18'(r_w);
            wheel_c[1] = -18'(r_f) + 18'(r_s) + 18'(r_w);
            wheel_c[2] = 18'(r_f) - 18'(r_s) + 18'(r_w);
            wheel_c[3] = -18'(r_f) - 18'(r_s) + 18'(r_w);
        end else begin
            for (int i = 0; i < 4; i++) wheel_c[i] = '0;
        end
        max_c = '0;
        for (int i = 0; i < 4; i++) begin
            mag_c[i] = wheel_c[i] < 0 ? 17'(-wheel_c[i]) : 17'(wheel_c[i]);
            if (mag_c[i] > max_c) max_c = mag_c[i];
        end
        for (int i = 0; i < 4; i++) m_c[i] = -17'(r_meas[i]);
        comb_c[0] = 20'(m_c[0]) - 20'(m_c[1]) + 20'(m_c[2]) - 20'(m_c[3]);
        comb_c[1] = 20'(m_c[0]) + 20'(m_c[1]) - 20'(m_c[2]) - 20'(m_c[3]);
        comb_c[2] = 20'(m_c[0]) + 20'(m_c[1]) + 20'(m_c[2]) + 20'(m_c[3]);
        for (int i = 0; i < 3; i++) quar_c[i] = quarter_sat(comb_c[i]);
    end

    assign sq_sum = r_sqf + r_sqs;

    // Division and square root steps.
    logic [15:0] prod_lo [4];
    logic [17:0] trial [4];
    logic [31:0] sq_try;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            prod_lo[i] = r_prod[i][15:0];
            trial[i]   = {r_rem[i], prod_lo[i][~i_cmd.cnt]};
        end
        sq_try = r_res + r_one;
    end

    // Result formation and acceleration update.
    logic               do_scale;
    logic signed [15:0] tgt_c [4];
    logic signed [17:0] thr_enter, thr_exit, trav_s;
    logic               act_h, act_n;
    logic [8:0]         tick_inc;
    logic [7:0]         ticks_n;

    always_comb begin
        do_scale = r_max > {2'b0, i_cfg.wheel_limit};
        for (int i = 0; i < 4; i++) begin
            if (do_scale) tgt_c[i] = r_wheel[i] < 0 ? r_quo[i] : -r_quo[i];
            else          tgt_c[i] = 16'(-r_wheel[i]);
        end
        trav_s    = $signed({2'b0, r_res[15:0]});
        thr_enter = $signed({2'b0, r_tgt}) - $signed({2'b0, i_cfg.enter_margin});
        thr_exit  = $signed({2'b0, r_tgt}) - $signed({2'b0, i_cfg.exit_margin});
        if (trav_s < thr_enter)     act_h = 1'b1;
        else if (trav_s > thr_exit) act_h = 1'b0;
        else                        act_h = r_act;
        tick_inc = {1'b0, r_ticks} + 9'd1;
        act_n    = act_h;
        ticks_n  = '0;
        if (act_h) begin
            if (tick_inc > {1'b0, i_cfg.timeout}) act_n = 1'b0;
            else ticks_n = tick_inc[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_mode    <= i_normal_mode;
            r_f       <= i_cmd_forward;
            r_s       <= i_cmd_sideways;
            r_w       <= i_cmd_spin;
            r_tgt     <= i_target_travel;
            r_meas[0] <= i_meas_left_front;
            r_meas[1] <= i_meas_right_front;
            r_meas[2] <= i_meas_left_back;
            r_meas[3] <= i_meas_right_back;
        end
        if (i_cmd.prep) begin
            for (int i = 0; i < 4; i++) begin
                r_wheel[i] <= wheel_c[i];
                r_mag[i]   <= mag_c[i];
            end
            r_max <= max_c;
            r_bf  <= quar_c[0];
            r_bs  <= quar_c[1];
            r_bw  <= quar_c[2];
        end
        if (i_cmd.mul) begin
            for (int i = 0; i < 4; i++) r_prod[i] <= r_mag[i] * i_cfg.wheel_limit;
            r_sqf <= 32'($signed(r_bf) * $signed(r_bf));
            r_sqs <= 32'($signed(r_bs) * $signed(r_bs));
        end
        if (i_cmd.init) begin
            for (int i = 0; i < 4; i++) begin
                r_rem[i] <= {1'b0, r_prod[i][31:16]};
                r_quo[i] <= '0;
            end
            r_op  <= sq_sum;
            r_res <= '0;
            r_one <= 32'h4000_0000;
        end
        if (i_cmd.step) begin
            for (int i = 0; i < 4; i++) begin
                if (trial[i] >= {1'b0, r_max}) begin
                    r_rem[i] <= 17'(trial[i] - {1'b0, r_max});
                    r_quo[i] <= {r_quo[i][14:0], 1'b1};
                end else begin
                    r_rem[i] <= trial[i][16:0];
                    r_quo[i] <= {r_quo[i][14:0], 1'b0};
                end
            end
            if (r_op >= sq_try) begin
                r_op  <= r_op - sq_try;
                r_res <= (r_res >> 1) + r_one;
            end else begin
                r_res <= r_res >> 1;
            end
            r_one <= r_one >> 2;
        end
        if (i_cmd.ld_out) begin
            o_target_left_front  <= tgt_c[0];
            o_target_right_front <= tgt_c[1];
            o_target_left_back   <= tgt_c[2];
            o_target_right_back  <= tgt_c[3];
            o_body_forward       <= r_bf;
            o_body_sideways      <= r_bs;
            o_body_spin          <= r_bw;
            o_travel_magnitude   <= r_res[15:0];
            o_accel_flag         <= act_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_ticks <= '0;
        end else if (i_cmd.ld_out) begin
            r_act   <= act_n;
            r_ticks <= ticks_n;
        end
    end

endmodule
`default_nettype wire

// ----- src/ocwm_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ocwm_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] o_travel_magnitude
);

    // A result held for the receiver stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result withdrawn before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_travel_magnitude))
        else $error("result changed while stalled");

    // One item at a time: accepting an item closes the input.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item accepted while one is in work");

    // A result never appears straight after an item is taken.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !$rose(o_out_valid))
        else $error("result produced too early");

    // Loading a result returns the block to idle.
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("block not idle after result load");

endmodule

bind omni_chassis_wheel_mixer_unit ocwm_chk u_ocwm_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_travel_magnitude (o_travel_magnitude)
);
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import ocwm_pkg::*;

    // The run is stopped well beyond the slowest correct run: roughly 500 items,
    // plus sender gaps, receiver stalls and the long hold-off.
    localparam int unsigned CYCLE_LIMIT = 600000;
    // A register index that the block does not decode; writes to it must be ignored.
    localparam logic [7:0] CFG_IDX_UNUSED = 8'd9;
    // Cycles to let pass once the last result has come, before going on.
    localparam int unsigned SETTLE_CYCLES = 30;

    typedef struct {
        logic               normal_mode;
        logic signed [15:0] cmd_forward;
        logic signed [15:0] cmd_sideways;
        logic signed [15:0] cmd_spin;
        logic [15:0]        target_travel;
        logic signed [15:0] meas_lf;
        logic signed [15:0] meas_rf;
        logic signed [15:0] meas_lb;
        logic signed [15:0] meas_rb;
    } t_tick;

    typedef struct {
        logic signed [15:0] tgt_lf;
        logic signed [15:0] tgt_rf;
        logic signed [15:0] tgt_lb;
        logic signed [15:0] tgt_rb;
        logic signed [15:0] body_fwd;
        logic signed [15:0] body_side;
        logic signed [15:0] body_spin;
        logic [15:0]        travel;
        logic               accel;
    } t_wheel_out;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_normal_mode;
    logic signed [15:0] i_cmd_forward;
    logic signed [15:0] i_cmd_sideways;
    logic signed [15:0] i_cmd_spin;
    logic [15:0]        i_target_travel;
    logic signed [15:0] i_meas_left_front;
    logic signed [15:0] i_meas_right_front;
    logic signed [15:0] i_meas_left_back;
    logic signed [15:0] i_meas_right_back;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [15:0] o_target_left_front;
    logic signed [15:0] o_target_right_front;
    logic signed [15:0] o_target_left_back;
    logic signed [15:0] o_target_right_back;
    logic signed [15:0] o_body_forward;
    logic signed [15:0] o_body_sideways;
    logic signed [15:0] o_body_spin;
    logic [15:0]        o_travel_magnitude;
    logic               o_accel_flag;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    omni_chassis_wheel_mixer_unit DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_normal_mode       (i_normal_mode),
        .i_cmd_forward       (i_cmd_forward),
        .i_cmd_sideways      (i_cmd_sideways),
        .i_cmd_spin          (i_cmd_spin),
        .i_target_travel     (i_target_travel),
        .i_meas_left_front   (i_meas_left_front),
        .i_meas_right_front  (i_meas_right_front),
        .i_meas_left_back    (i_meas_left_back),
        .i_meas_right_back   (i_meas_right_back),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_target_left_front (o_target_left_front),
        .o_target_right_front(o_target_right_front),
        .o_target_left_back  (o_target_left_back),
        .o_target_right_back (o_target_right_back),
        .o_body_forward      (o_body_forward),
        .o_body_sideways     (o_body_sideways),
        .o_body_spin         (o_body_spin),
        .o_travel_magnitude  (o_travel_magnitude),
        .o_accel_flag        (o_accel_flag),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // Shadow copy of the configuration registers and of the acceleration state.
    t_cfg        shadow_cfg;
    logic        accel_active_q;
    logic [7:0]  accel_ticks_q;

    // Wheel results still owed by the block, oldest first.
    t_wheel_out  owed_results[$];
    int unsigned mismatches;
    int unsigned cycles;

    // Receiver behaviour: a long hold-off on demand, otherwise random stalls.
    logic        rx_hold;
    logic        rx_steady;
    int unsigned rx_wait;
    // When set, the sender offers items with no added gaps.
    logic        tx_steady;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Most gaps are short, a few are long enough to cover a whole item.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 25);
        return $urandom_range(26, 80);
    endfunction

    // Integer square root, truncated, by bisection.
    function automatic longint isqrt(input longint n);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 65536;
        while (lo + 1 < hi) begin
            mid = (lo + hi) / 2;
            if (mid * mid <= n) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    // A quarter of a wheel combination, truncated toward zero and saturated.
    function automatic longint quarter_clamp(input longint v);
        longint q;
        q = v / 4;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q;
    endfunction

    // Works out the result of one tick and advances the acceleration state.
    function automatic t_wheel_out mix_tick(input t_tick t);
        t_wheel_out r;
        longint     wh[4];
        longint     m[4];
        longint     mag;
        longint     peak;
        longint     lim;
        longint     bf;
        longint     bs;
        longint     bw;
        longint     trav;
        longint     tgt;
        int unsigned nxt;
        longint     f;
        longint     s;
        longint     w;
        f = t.cmd_forward;
        s = t.cmd_sideways;
        w = t.cmd_spin;
        for (int i = 0; i < 4; i++) wh[i] = 0;
        if (t.normal_mode) begin
            wh[0] = f + s + w;
            wh[1] = -f + s + w;
            wh[2] = f - s + w;
            wh[3] = -f - s + w;
        end
        peak = 0;
        for (int i = 0; i < 4; i++) begin
            mag = (wh[i] < 0) ? -wh[i] : wh[i];
            if (mag > peak) peak = mag;
        end
        lim = shadow_cfg.wheel_limit;
        if (peak > lim) begin
            for (int i = 0; i < 4; i++) begin
                mag = (wh[i] < 0) ? -wh[i] : wh[i];
                mag = mag * lim / peak;
                wh[i] = (wh[i] < 0) ? -mag : mag;
            end
        end
        m[0] = -longint'(t.meas_lf);
        m[1] = -longint'(t.meas_rf);
        m[2] = -longint'(t.meas_lb);
        m[3] = -longint'(t.meas_rb);
        bf = quarter_clamp(m[0] - m[1] + m[2] - m[3]);
        bs = quarter_clamp(m[0] + m[1] - m[2] - m[3]);
        bw = quarter_clamp(m[0] + m[1] + m[2] + m[3]);
        trav = isqrt(bf * bf + bs * bs);
        tgt = t.target_travel;

        // Hysteresis: the thresholds may go negative, and then compare as signed.
        if (trav < tgt - longint'(shadow_cfg.enter_margin)) accel_active_q = 1'b1;
        else if (trav > tgt - longint'(shadow_cfg.exit_margin)) accel_active_q = 1'b0;
        if (accel_active_q) begin
            nxt = accel_ticks_q + 1;
            if (nxt > shadow_cfg.timeout) begin
                accel_active_q = 1'b0;
                accel_ticks_q  = '0;
            end else begin
                accel_ticks_q = nxt[7:0];
            end
        end else begin
            accel_ticks_q = '0;
        end

        r.tgt_lf    = 16'(-wh[0]);
        r.tgt_rf    = 16'(-wh[1]);
        r.tgt_lb    = 16'(-wh[2]);
        r.tgt_rb    = 16'(-wh[3]);
        r.body_fwd  = 16'(bf);
        r.body_side = 16'(bs);
        r.body_spin = 16'(bw);
        r.travel    = 16'(trav);
        r.accel     = accel_active_q;
        return r;
    endfunction

    // Signed 16 bit value leaning towards the extremes and towards zero.
    function automatic logic [15:0] pick_speed();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 16'h7fff;
        if (r < 16) return 16'h8000;
        if (r < 30) return 16'($signed($urandom_range(0, 2000)) - 1000);
        if (r < 55) return 16'($signed($urandom_range(0, 20000)) - 10000);
        return 16'($urandom);
    endfunction

    // A random tick; targets often sit far above the measured travel so that
    // the acceleration flag is raised, held and timed out.
    function automatic t_tick pick_tick();
        t_tick t;
        int unsigned r;
        t.normal_mode  = ($urandom_range(0, 9) != 0);
        t.cmd_forward  = pick_speed();
        t.cmd_sideways = pick_speed();
        t.cmd_spin     = pick_speed();
        r = $urandom_range(0, 99);
        if (r < 50) begin
            t.meas_lf = 16'($signed($urandom_range(0, 4000)) - 2000);
            t.meas_rf = 16'($signed($urandom_range(0, 4000)) - 2000);
            t.meas_lb = 16'($signed($urandom_range(0, 4000)) - 2000);
            t.meas_rb = 16'($signed($urandom_range(0, 4000)) - 2000);
        end else begin
            t.meas_lf = pick_speed();
            t.meas_rf = pick_speed();
            t.meas_lb = pick_speed();
            t.meas_rb = pick_speed();
        end
        r = $urandom_range(0, 99);
        if (r < 35)      t.target_travel = 16'($urandom_range(40000, 65535));
        else if (r < 45) t.target_travel = 16'hffff;
        else if (r < 55) t.target_travel = '0;
        else             t.target_travel = 16'($urandom);
        return t;
    endfunction

    function automatic t_tick make_tick(input logic mode, input logic [15:0] f,
                                        input logic [15:0] s, input logic [15:0] w,
                                        input logic [15:0] tgt, input logic [15:0] lf,
                                        input logic [15:0] rf, input logic [15:0] lb,
                                        input logic [15:0] rb);
        t_tick t;
        t.normal_mode   = mode;
        t.cmd_forward   = f;
        t.cmd_sideways  = s;
        t.cmd_spin      = w;
        t.target_travel = tgt;
        t.meas_lf       = lf;
        t.meas_rf       = rf;
        t.meas_lb       = lb;
        t.meas_rb       = rb;
        return t;
    endfunction

    // Offers one item and holds it until the block takes it. Ready is looked at
    // on the falling edge, where it is stable up to the next rising edge. Valid
    // is low between items; the block is busy then anyway.
    task automatic send_tick(input t_tick t);
        int unsigned gap;
        logic        taken;
        gap = tx_steady ? 0 : pick_gap();
        repeat (gap + 1) @(posedge i_clk);
        owed_results.push_back(mix_tick(t));
        i_in_valid         <= 1'b1;
        i_normal_mode      <= t.normal_mode;
        i_cmd_forward      <= t.cmd_forward;
        i_cmd_sideways     <= t.cmd_sideways;
        i_cmd_spin         <= t.cmd_spin;
        i_target_travel    <= t.target_travel;
        i_meas_left_front  <= t.meas_lf;
        i_meas_right_front <= t.meas_rf;
        i_meas_left_back   <= t.meas_lb;
        i_meas_right_back  <= t.meas_rb;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b0;
    endtask

    // Register writes only happen once the block has delivered everything
    // and has had time to finish any work still in flight.
    task automatic wait_idle();
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
        logic taken;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        case (idx)
            {6'd0, REG_WHEEL_LIMIT}:  shadow_cfg.wheel_limit  = data[14:0];
            {6'd0, REG_ENTER_MARGIN}: shadow_cfg.enter_margin = data;
            {6'd0, REG_EXIT_MARGIN}:  shadow_cfg.exit_margin  = data;
            {6'd0, REG_TIMEOUT}:      shadow_cfg.timeout      = data[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] lim, input logic [15:0] enter,
                              input logic [15:0] leave, input logic [15:0] tmo);
        wait_idle();
        write_reg({6'd0, REG_WHEEL_LIMIT}, lim);
        write_reg({6'd0, REG_ENTER_MARGIN}, enter);
        write_reg({6'd0, REG_EXIT_MARGIN}, leave);
        write_reg({6'd0, REG_TIMEOUT}, tmo);
    endtask

    // Extremes of every field and the special cases, under the reset defaults.
    task automatic test_directed_defaults();
        send_tick(make_tick(1'b1, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff,
                            16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        send_tick(make_tick(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h0000,
                            16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_tick(make_tick(1'b1, 16'h8000, 16'h7fff, 16'h0000, 16'h8000,
                            16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
        // Drive mode off: wheel targets must be zero whatever is commanded.
        send_tick(make_tick(1'b0, 16'h7fff, 16'h8000, 16'h7fff, 16'h1234,
                            16'h0001, 16'hffff, 16'h8000, 16'h7fff));
        send_tick(make_tick(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0000, 16'h0000));
        // At the limit, where no scaling takes place, and one above it.
        send_tick(make_tick(1'b1, 16'd4000, 16'd4000, 16'd0, 16'hffff,
                            16'h0003, 16'hfffd, 16'h0002, 16'hfffe));
        send_tick(make_tick(1'b1, 16'd4000, 16'd4000, 16'd1, 16'hffff,
                            16'h0000, 16'h0000, 16'h0000, 16'h0000));
        // A large target keeps the flag up for a few ticks.
        repeat (4) send_tick(make_tick(1'b1, 16'd100, 16'hff00, 16'd7, 16'hffff,
                                       16'd10, 16'd20, 16'd30, 16'd40));
    endtask

    // Extreme register settings: zero and full wheel limits, margins that make
    // the thresholds negative, a timeout of one, and at the end the longest one.
    task automatic test_register_extremes();
        set_config(16'd0, 16'hffff, 16'hffff, 16'd1);
        send_tick(make_tick(1'b1, 16'd1, 16'd0, 16'd0, 16'hffff,
                            16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_tick(make_tick(1'b1, 16'h8000, 16'h7fff, 16'h8000, 16'h0000,
                            16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
        set_config(16'h7fff, 16'd0, 16'd0, 16'd1);
        repeat (3) send_tick(make_tick(1'b1, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff,
                                       16'd0, 16'd0, 16'd0, 16'd0));
        // An index the block does not decode must leave every register alone.
        wait_idle();
        write_reg(CFG_IDX_UNUSED, 16'h0000);
        send_tick(make_tick(1'b1, 16'd30000, 16'd30000, 16'd0, 16'h0000,
                            16'd5, 16'd5, 16'd5, 16'd5));
        set_config(16'd8000, 16'd4000, 16'd1500, 16'd255);
    endtask

    task automatic test_random_sweep(input int unsigned n_items);
        int unsigned r;
        for (int k = 0; k < n_items; k++) begin
            // Change the register set now and then, always while idle.
            if (k % 60 == 59) begin
                r = $urandom_range(0, 3);
                case (r)
                    0: set_config(16'($urandom_range(0, 32767)), 16'($urandom),
                                  16'($urandom), 16'($urandom_range(1, 255)));
                    1: set_config(16'($urandom_range(0, 500)), 16'($urandom_range(0, 3000)),
                                  16'($urandom_range(0, 3000)), 16'($urandom_range(1, 8)));
                    2: set_config(16'h7fff, 16'h0000, 16'hffff, 16'd255);
                    default: set_config(16'd8000, 16'd4000, 16'd1500, 16'd200);
                endcase
            end
            tx_steady = (k % 100) >= 80;
            rx_steady <= ((k % 100) >= 70) && ((k % 100) < 90);
            send_tick(pick_tick());
        end
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
    endtask

    // The receiver refuses results for a long stretch while the sender keeps
    // offering items, so the block fills and stops taking input.
    task automatic test_receiver_hold_off();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (400) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            begin
                tx_steady = 1'b1;
                repeat (8) send_tick(pick_tick());
                tx_steady = 1'b0;
            end
        join
    endtask

    // The sender pauses until every owed result has arrived, then resumes.
    task automatic test_sender_pause();
        repeat (6) send_tick(pick_tick());
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (6) send_tick(pick_tick());
    endtask

    // Receiver: ready is driven at the rising edge, with random stalls.
    always @(posedge i_clk) begin
        if (rx_hold) begin
            i_out_ready <= 1'b0;
        end else if (rx_wait != 0) begin
            i_out_ready <= 1'b0;
            rx_wait     <= rx_wait - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 3) == 0) rx_wait <= pick_gap();
        end
    end

    // Result checker: a result is taken at the next rising edge when valid and
    // ready are both high on the falling edge before it.
    always @(negedge i_clk) begin
        t_wheel_out exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                exp_r = owed_results.pop_front();
                if (o_target_left_front !== exp_r.tgt_lf || o_target_right_front !== exp_r.tgt_rf
                    || o_target_left_back !== exp_r.tgt_lb
                    || o_target_right_back !== exp_r.tgt_rb
                    || o_body_forward !== exp_r.body_fwd || o_body_sideways !== exp_r.body_side
                    || o_body_spin !== exp_r.body_spin || o_travel_magnitude !== exp_r.travel
                    || o_accel_flag !== exp_r.accel) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at cycle %0d", cycles);
                        $display("  expected wheels %0d %0d %0d %0d body %0d %0d %0d trav %0d acc %0b",
                                 exp_r.tgt_lf, exp_r.tgt_rf, exp_r.tgt_lb, exp_r.tgt_rb,
                                 exp_r.body_fwd, exp_r.body_side, exp_r.body_spin,
                                 exp_r.travel, exp_r.accel);
                        $display("  actual   wheels %0d %0d %0d %0d body %0d %0d %0d trav %0d acc %0b",
                                 o_target_left_front, o_target_right_front,
                                 o_target_left_back, o_target_right_back, o_body_forward,
                                 o_body_sideways, o_body_spin, o_travel_magnitude, o_accel_flag);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int unsigned drain;
        cycles             = 0;
        mismatches         = 0;
        rx_wait            = 0;
        rx_hold            = 1'b0;
        rx_steady          = 1'b0;
        tx_steady          = 1'b0;
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_out_ready        = 1'b0;
        i_normal_mode      = 1'b0;
        i_cmd_forward      = '0;
        i_cmd_sideways     = '0;
        i_cmd_spin         = '0;
        i_target_travel    = '0;
        i_meas_left_front  = '0;
        i_meas_right_front = '0;
        i_meas_left_back   = '0;
        i_meas_right_back  = '0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        shadow_cfg.wheel_limit  = 15'd8000;
        shadow_cfg.enter_margin = 16'd4000;
        shadow_cfg.exit_margin  = 16'd1500;
        shadow_cfg.timeout      = 8'd200;
        accel_active_q = 1'b0;
        accel_ticks_q  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_defaults();
        test_register_extremes();
        test_receiver_hold_off();
        test_sender_pause();
        test_random_sweep(420);

        // Drain: wait for the last results, then a little longer.
        drain = 0;
        while (owed_results.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ----- omni_chassis_wheel_mixer_unit.f -----
src/ocwm_pkg.sv
src/ocwm_ctrl.sv
src/ocwm_dp.sv
src/omni_chassis_wheel_mixer_unit.sv
src/ocwm_chk.sv
dv/tb.sv
